FILE: hdl/fnvrw_pkg.sv
// Shared constants, types and state codes for the word-wise FNV rotate hash.
`timescale 1ns / 1ps
package fnvrw_pkg;

    // FNV-64 offset basis, loaded into the seed register at reset.
    localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    // The FNV-64 prime is 2^40 + 0x1b3, so a multiply splits into a shift and a narrow product.
    localparam int          PRIME_SHIFT = 40;
    localparam logic [8:0]  PRIME_LO    = 9'h1b3;

    // Default left rotation applied after each mixing step.
    localparam int          ROTATE_BITS_DEF = 13;

    // Bytes in one full word.
    localparam logic [3:0]  WORD_BYTES = 4'd8;

    // Control request from the sequencer to the mixing unit.
    typedef struct packed {
        logic start;
        logic rot_en;
    } mix_ctl_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX,
        S_WAIT,
        S_FIN,
        S_FIN_WAIT,
        S_OUT
    } state_t;

endpackage

FILE: hdl/fnv_rotate_word_hash64.sv
// Top level of the word-wise FNV-1a rotate hash: sequencer, counters and ports.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake               Payload
// cfg       in         cfg_valid / cfg_ready   cfg_data (seed, 64 bits)
// in        in         in_valid / in_stall     data_word, byte_count, last
// out       out        out_valid / out_stall   hash, msg_bytes, full_words
//
// A full word is mixed in one step; a partial word with n bytes is mixed in n steps,
// one byte per step, on the shared mixing unit (issue, XOR stage, multiply and rotate
// stage). The next request is taken only after the last step of an item has finished.
// A last item adds a length mix and then loads the result into the output register.
// The input is stalled whenever the sequencer is busy; after the length mix it also
// stays stalled while a finished result waits for the previous one to be taken.
// Reset loads the seed with the FNV offset basis and clears the sequencer state, the message flag and the valid flags.
//
module fnv_rotate_word_hash64 #(
    parameter int ROTATE_BITS = fnvrw_pkg::ROTATE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] data_word,
    input  logic [3:0]  byte_count,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] hash,
    output logic [63:0] msg_bytes,
    output logic [60:0] full_words
);
    import fnvrw_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    logic [63:0] seed_reg;
    logic        in_msg_reg;
    logic [63:0] hash_reg;
    logic [63:0] bytes_reg;
    logic [60:0] words_reg;
    logic [63:0] data_reg;
    logic [3:0]  cnt_reg;
    logic        full_reg;
    logic        last_reg;
    logic [2:0]  idx_reg;
    logic        out_valid_reg;
    logic [63:0] out_hash_reg;
    logic [63:0] out_bytes_reg;
    logic [60:0] out_words_reg;

    logic        in_take;
    logic        out_take;
    logic        out_free;
    logic        more_bytes;
    logic [3:0]  cnt_sat;
    mix_ctl_t    mix_ctl;
    logic [63:0] mix_operand;
    logic        mix_done;
    logic [63:0] mix_result;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cnt_sat   = byte_count[3] ? WORD_BYTES : byte_count;
    assign more_bytes = !full_reg && (({1'b0, idx_reg} + 4'd1) < cnt_reg);

    // Seed register, written through the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= FNV_BASIS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            seed_reg <= cfg_data;
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and requests to the mixing unit.
    always_comb
    begin
        state_next     = state_reg;
        mix_ctl.start  = 1'b0;
        mix_ctl.rot_en = 1'b1;
        mix_operand    = full_reg ? data_reg : {56'd0, data_reg[{idx_reg, 3'b000} +: 8]};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (cnt_sat != 4'd0)
                    begin
                        state_next = S_MIX;
                    end
                    else if (last)
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MIX:
            begin
                mix_ctl.start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (mix_done)
                begin
                    if (more_bytes)
                    begin
                        state_next = S_MIX;
                    end
                    else if (last_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIN:
            begin
                mix_ctl.start  = 1'b1;
                mix_ctl.rot_en = 1'b0;
                mix_operand    = bytes_reg;
                state_next     = S_FIN_WAIT;
            end
            S_FIN_WAIT:
            begin
                if (mix_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Message flag: set by the first request of a message, cleared when the result is loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_msg_reg <= 1'b1;
        end
        else if (state_reg == S_OUT && out_free)
        begin
            in_msg_reg <= 1'b0;
        end
    end

    // Item capture, running hash and message counters.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            data_reg <= data_word;
            cnt_reg  <= cnt_sat;
            full_reg <= byte_count[3];
            last_reg <= last;
            idx_reg  <= 3'd0;
            if (!in_msg_reg)
            begin
                hash_reg  <= seed_reg;
                bytes_reg <= {60'd0, cnt_sat};
                words_reg <= {60'd0, byte_count[3]};
            end
            else
            begin
                bytes_reg <= bytes_reg + {60'd0, cnt_sat};
                words_reg <= words_reg + {60'd0, byte_count[3]};
            end
        end
        else if (state_reg == S_WAIT && mix_done)
        begin
            hash_reg <= mix_result;
            if (more_bytes)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    // Result register, parting the sequencer from the output channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            out_hash_reg  <= mix_result;
            out_bytes_reg <= bytes_reg;
            out_words_reg <= words_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign hash        = out_hash_reg;
    assign msg_bytes   = out_bytes_reg;
    assign full_words  = out_words_reg;

    // Shared XOR, multiply and rotate unit.
    fnvrw_mix_unit #(
        .ROTATE_BITS (ROTATE_BITS)
    ) u_mix (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mix_ctl),
        .hash_in (hash_reg),
        .operand (mix_operand),
        .done    (mix_done),
        .result  (mix_result)
    );

    // The mixing unit only finishes a step while the sequencer is waiting for it.
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mix_done |-> (state_reg == S_WAIT || state_reg == S_FIN_WAIT))
        else $error("mixing step finished outside a wait state");

    // A request issued to the mixing unit completes after passing the stage valid and done registers.
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        mix_ctl.start |-> ##2 mix_done)
        else $error("mixing step latency is not two cycles");

    // A full word within a message advances the word counter by one.
    a_word_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && byte_count[3] && in_msg_reg) |=>
            (words_reg == $past(words_reg) + 61'd1))
        else $error("full word did not advance the word counter");

    // A waiting result is never overwritten.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(out_hash_reg))
        else $error("stalled result was overwritten");

    // The byte loop never runs past the captured count.
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX && !full_reg) |-> ({1'b0, idx_reg} < cnt_reg))
        else $error("byte index ran past the byte count");

endmodule

FILE: hdl/fnvrw_mix_unit.sv
// Shared mixing unit: XOR, multiply by the FNV-64 prime, optional rotate.
`timescale 1ns / 1ps
module fnvrw_mix_unit #(
    parameter int ROTATE_BITS = fnvrw_pkg::ROTATE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fnvrw_pkg::mix_ctl_t ctl,
    input  logic [63:0]         hash_in,
    input  logic [63:0]         operand,
    output logic                done,
    output logic [63:0]         result
);
    import fnvrw_pkg::*;

    logic [63:0] x_reg;
    logic        rot_reg;
    logic        stage_vld_reg;
    logic        done_reg;
    logic [63:0] result_reg;
    logic [63:0] lo_prod;
    logic [63:0] prod;
    logic [63:0] rotated;

    // First stage: fold the operand into the hash.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
        end
        else
        begin
            stage_vld_reg <= ctl.start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            x_reg   <= hash_in ^ operand;
            rot_reg <= ctl.rot_en;
        end
    end

    // Second stage: multiply modulo 2^64 as a shifted copy plus a narrow product.
    always_comb
    begin
        lo_prod = x_reg * {55'd0, PRIME_LO};
        prod    = lo_prod + {x_reg[63-PRIME_SHIFT:0], {PRIME_SHIFT{1'b0}}};
        rotated = (prod << ROTATE_BITS) | (prod >> (64 - ROTATE_BITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_vld_reg;
        end
    end

    // The result holds until the next request is issued.
    always_ff @(posedge clk)
    begin
        if (stage_vld_reg)
        begin
            result_reg <= rot_reg ? rotated : prod;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
